/* hdl/sorted_table_binary_search_unit_macros.svh */
// Assertion macros shared by the sorted table binary search unit.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STBS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/stbs_pkg.sv */
// Package for the sorted table binary search unit: field widths, command codes
// and the control struct passed from the front queue to the search engine.
package stbs_pkg;

    localparam int CMD_W    = 1;
    localparam int INDEX_W  = 10;
    localparam int KEY_IN_W = 32;
    localparam int COUNT_W  = 11;

    localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 1'b1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    typedef struct packed {
        logic valid;
        logic search;
    } q_ctrl_t;

endpackage

/* hdl/stbs_if.sv */
// Channel interfaces of the sorted table binary search unit: item, result and
// configuration. Depends on stbs_pkg for the field widths.
interface stbs_item_if;
    import stbs_pkg::*;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [INDEX_W-1:0]  entry_index;
    logic [KEY_IN_W-1:0] key;
    modport source (output valid, cmd, entry_index, key, input ready);
    modport sink (input valid, cmd, entry_index, key, output ready);
endinterface

interface stbs_result_if;
    import stbs_pkg::*;
    logic               valid;
    logic               ready;
    logic               found;
    logic [INDEX_W-1:0] match_index;
    modport source (output valid, found, match_index, input ready);
    modport sink (input valid, found, match_index, output ready);
endinterface

interface stbs_cfg_if;
    import stbs_pkg::*;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] entry_count;
    modport source (output valid, entry_count, input ready);
    modport sink (input valid, entry_count, output ready);
endinterface

/* hdl/stbs_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the identifier table.
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/stbs_front.sv */
// Front end: accepts item beats, drops writes beyond the table and queues the
// rest for the search engine. Depends on stbs_pkg and stbs_if.
module stbs_front #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH = 32,
    localparam int ADDR_W = $clog2(TABLE_DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    stbs_item_if.sink             item,
    output stbs_pkg::q_ctrl_t     head,
    output logic [KEY_WIDTH-1:0]  head_key,
    output logic [ADDR_W-1:0]     head_addr,
    input  logic                  pop
);
    import stbs_pkg::*;

    logic [KEY_WIDTH+KEY_IN_W-1:0] key_wide;
    logic [ADDR_W+INDEX_W-1:0]     addr_wide;
    logic                          in_range;
    logic                          keep;
    logic                          push;

    logic                 search_q_reg [Q_DEPTH];
    logic [KEY_WIDTH-1:0] key_q_reg    [Q_DEPTH];
    logic [ADDR_W-1:0]    addr_q_reg   [Q_DEPTH];

    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]   fill_reg, fill_next;

    assign key_wide  = {{KEY_WIDTH{1'b0}}, item.key};
    assign addr_wide = {{ADDR_W{1'b0}}, item.entry_index};
    assign in_range  = 32'(item.entry_index) < 32'(TABLE_DEPTH);

    // A write outside the table is taken and dropped here.
    assign keep = (item.cmd == CMD_SEARCH) || in_range;

    assign item.ready = fill_reg != (Q_PTR_W + 1)'(Q_DEPTH);
    assign push       = item.valid && item.ready && keep;

    assign head.valid  = fill_reg != '0;
    assign head.search = search_q_reg[rd_ptr_reg];
    assign head_key    = key_q_reg[rd_ptr_reg];
    assign head_addr   = addr_q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            search_q_reg[wr_ptr_reg] <= item.cmd == CMD_SEARCH;
            key_q_reg[wr_ptr_reg]    <= key_wide[KEY_WIDTH-1:0];
            addr_q_reg[wr_ptr_reg]   <= addr_wide[ADDR_W-1:0];
        end
    end

endmodule

/* hdl/stbs_back.sv */
// Back end: executes queued table writes and runs the lower-bound search, one
// probe per cycle on the table RAM. Depends on stbs_pkg, stbs_if and stbs_ram.
`include "sorted_table_binary_search_unit_macros.svh"

module stbs_back #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH = 32,
    localparam int ADDR_W = $clog2(TABLE_DEPTH),
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  stbs_pkg::q_ctrl_t             head,
    input  logic [KEY_WIDTH-1:0]          head_key,
    input  logic [ADDR_W-1:0]             head_addr,
    output logic                          pop,
    input  logic [stbs_pkg::COUNT_W-1:0]  entry_count,
    stbs_result_if.source                 result
);
    import stbs_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [ADDR_W-1:0] lo_reg, lo_next;
    logic [ADDR_W-1:0] hi_reg, hi_next;
    logic [ADDR_W-1:0] mid_reg, mid_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic empty_reg, empty_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_found_reg;
    logic [INDEX_W-1:0] out_index_reg;

    logic                 ram_we;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [KEY_WIDTH-1:0] ram_rdata;

    logic [CNT_W-1:0]  n_sat;
    logic [ADDR_W-1:0] hi_start;
    logic              less;
    logic [ADDR_W-1:0] lo_p;
    logic [ADDR_W-1:0] hi_p;
    logic [ADDR_W:0]   sum_p;
    logic [ADDR_W-1:0] mid_p;
    logic              out_free;
    logic              load_out;
    logic              hit;
    logic [ADDR_W+INDEX_W-1:0] index_wide;

    stbs_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_addr),
        .wdata (head_key),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A count above the table depth covers the whole table.
    always_comb
    begin
        if (32'(entry_count) > 32'(TABLE_DEPTH))
        begin
            n_sat = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            n_sat = CNT_W'(entry_count);
        end
    end

    assign hi_start = ADDR_W'(n_sat - CNT_W'(1));

    // One halving step on the entry read back for the current midpoint.
    assign less  = ram_rdata < key_reg;
    assign lo_p  = less ? mid_reg + 1'b1 : lo_reg;
    assign hi_p  = less ? hi_reg : mid_reg;
    assign sum_p = {1'b0, lo_p} + {1'b0, hi_p};
    assign mid_p = sum_p[ADDR_W:1];

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        empty_next = empty_reg;
        pop        = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = mid_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (!head.search)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        key_next = head_key;
                        lo_next  = '0;
                        hi_next  = hi_start;
                        if (n_sat == '0)
                        begin
                            empty_next = 1'b1;
                            state_next = ST_FINAL;
                        end
                        else
                        begin
                            empty_next = 1'b0;
                            ram_re     = 1'b1;
                            if (hi_start != '0)
                            begin
                                ram_raddr  = hi_start >> 1;
                                mid_next   = hi_start >> 1;
                                state_next = ST_PROBE;
                            end
                            else
                            begin
                                ram_raddr  = hi_start;
                                state_next = ST_FINAL;
                            end
                        end
                    end
                end
            end
            ST_PROBE:
            begin
                lo_next = lo_p;
                hi_next = hi_p;
                ram_re  = 1'b1;
                if (lo_p < hi_p)
                begin
                    ram_raddr = mid_p;
                    mid_next  = mid_p;
                end
                else
                begin
                    ram_raddr  = hi_p;
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                // The read data holds while no new read is issued.
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign hit        = !empty_reg && (ram_rdata == key_reg);
    assign index_wide = {{INDEX_W{1'b0}}, hi_reg};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        key_reg   <= key_next;
        empty_reg <= empty_next;
        if (load_out)
        begin
            out_found_reg <= hit;
            out_index_reg <= hit ? index_wide[INDEX_W-1:0] : '0;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.found       = out_found_reg;
    assign result.match_index = out_index_reg;

    `STBS_ASSERT_IMPLIES(a_probe_interval, clk, rst_n, state_reg == ST_PROBE, lo_reg < hi_reg, "probe on a collapsed interval")
    `STBS_ASSERT_IMPLIES(a_probe_mid, clk, rst_n, state_reg == ST_PROBE, mid_reg >= lo_reg && mid_reg < hi_reg, "midpoint outside the interval")
    `STBS_ASSERT_IMPLIES(a_port_exclusive, clk, rst_n, ram_we, !ram_re, "table read and write in one cycle")
    `STBS_ASSERT_NEXT(a_search_starts, clk, rst_n, state_reg == ST_IDLE && head.valid && head.search, state_reg != ST_IDLE, "search beat did not start a search")

endmodule

/* hdl/sorted_table_binary_search_unit.sv */
// Top level of the sorted table binary search unit: configuration register,
// front queue and search engine. Depends on stbs_pkg, stbs_if, stbs_front, stbs_back.
//
//  channel   dir   payload                        beat taken when
//  item      in    cmd, entry_index, key          item.valid && item.ready
//  result    out   found, match_index             result.valid && result.ready
//  cfg       in    entry_count                    cfg.valid && cfg.ready
//
// A write beat is executed as the engine pops it from the queue; a search probes the
// table one entry per cycle on the single read port of the table RAM, and a search
// over an empty table issues no read.
// Reset clears the entry count and all control state; table contents are undefined.
// A two-beat queue lets items be taken while the engine is busy; a finished search
// waits in its last cycle only while the result register still holds an untaken beat.
module sorted_table_binary_search_unit #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    stbs_item_if.sink      item,
    stbs_result_if.source  result,
    stbs_cfg_if.sink       cfg
);
    import stbs_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic [COUNT_W-1:0]   entry_count_reg, entry_count_next;
    q_ctrl_t              head;
    logic [KEY_WIDTH-1:0] head_key;
    logic [ADDR_W-1:0]    head_addr;
    logic                 pop;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        entry_count_next = entry_count_reg;
        if (cfg.valid)
        begin
            entry_count_next = cfg.entry_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
        end
    end

    stbs_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .head      (head),
        .head_key  (head_key),
        .head_addr (head_addr),
        .pop       (pop)
    );

    stbs_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_key    (head_key),
        .head_addr   (head_addr),
        .pop         (pop),
        .entry_count (entry_count_reg),
        .result      (result)
    );

endmodule

/* dv/tb_sorted_table_binary_search_unit.sv */
`timescale 1ns / 100ps
// Testbench for sorted_table_binary_search_unit: loads the identifier table, sets the entry
// count and checks every search result against a predictor held in a scoreboard class.
// Depends on stbs_pkg, the channel interfaces in stbs_if and the unit's RTL.
module tb_sorted_table_binary_search_unit;
    import stbs_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int MAX_COUNT = (1 << COUNT_W) - 1;
    localparam int DRAIN_CYCLES = 32;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int REPORT_LIMIT = 10;
    localparam int RANDOM_PHASES = 26;
    localparam int PHASE_ITEMS = 34;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] match_index;
    } lookup_result_t;

    typedef enum int {RX_ALWAYS, RX_ALTERNATE, RX_MOSTLY, RX_SPARSE} rx_pattern_t;

    class lookup_scoreboard;
        logic [KEY_IN_W-1:0] id_table [TABLE_DEPTH];
        int unsigned         entry_count;
        lookup_result_t      pending_results[$];
        int unsigned         mismatches;

        function new();
            entry_count = 0;
            mismatches = 0;
        endfunction

        function void set_entry_count(input logic [COUNT_W-1:0] n);
            entry_count = n;
        endfunction

        // Lower-bound search over the valid entries, then a single equality compare.
        function lookup_result_t search(input logic [KEY_IN_W-1:0] key);
            lookup_result_t res;
            int unsigned    n, lo, hi, mid;
            res = '0;
            n = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
            if (n == 0)
                return res;
            lo = 0;
            hi = n - 1;
            while (lo < hi)
            begin
                mid = (lo + hi) >> 1;
                if (id_table[mid] < key)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            if (id_table[hi] == key)
            begin
                res.found = 1'b1;
                res.match_index = INDEX_W'(hi);
            end
            return res;
        endfunction

        function void note_item(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                                input logic [KEY_IN_W-1:0] key);
            if (cmd == CMD_WRITE)
                id_table[idx] = key;
            else
                pending_results.push_back(search(key));
        endfunction

        function void check_result(input logic found, input logic [INDEX_W-1:0] idx);
            lookup_result_t exp;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result beat: found=%0b match_index=%0d", found, idx);
                return;
            end
            exp = pending_results.pop_front();
            if (found !== exp.found || idx !== exp.match_index)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"result mismatch: expected found=%0b match_index=%0d, ",
                              "got found=%0b match_index=%0d"},
                             exp.found, exp.match_index, found, idx);
            end
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    stbs_item_if   item_ch();
    stbs_result_if result_ch();
    stbs_cfg_if    cfg_ch();

    sorted_table_binary_search_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    lookup_scoreboard    sb;
    logic [KEY_IN_W-1:0] stim_table [TABLE_DEPTH];
    int unsigned         burst_left;
    bit                  gapless;
    bit                  hold_request;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && item_ch.valid && item_ch.ready)
            sb.note_item(item_ch.cmd, item_ch.entry_index, item_ch.key);
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.found, result_ch.match_index);
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
            sb.set_entry_count(cfg_ch.entry_count);
    end

    // The result side switches between stall patterns at random, and on request holds off
    // for a long stretch so that the unit backs up and stalls its input.
    initial
    begin
        rx_pattern_t pattern;
        int unsigned left;
        int unsigned hold;
        result_ch.ready = 1'b0;
        pattern = RX_ALWAYS;
        left = 0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold = LONG_HOLD_CYCLES;
            end
            if (hold != 0)
            begin
                hold--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    pattern = rx_pattern_t'($urandom_range(0, 3));
                    left = $urandom_range(16, 160);
                end
                left--;
                case (pattern)
                    RX_ALWAYS:    result_ch.ready <= 1'b1;
                    RX_ALTERNATE: result_ch.ready <= ~result_ch.ready;
                    RX_MOSTLY:    result_ch.ready <= ($urandom_range(0, 3) != 0);
                    default:      result_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] c, input logic [INDEX_W-1:0] idx,
                             input logic [KEY_IN_W-1:0] k);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = gapless ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        item_ch.valid <= 1'b1;
        item_ch.cmd <= c;
        item_ch.entry_index <= idx;
        item_ch.key <= k;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic write_entry(input int unsigned idx, input logic [KEY_IN_W-1:0] v);
        stim_table[idx] = v;
        send_item(CMD_WRITE, INDEX_W'(idx), v);
    endtask

    task automatic search_key(input logic [KEY_IN_W-1:0] k);
        send_item(CMD_SEARCH, INDEX_W'($urandom), k);
    endtask

    // Writes carry no result, so the unit may still be busy once nothing is expected.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_entry_count(input logic [COUNT_W-1:0] n);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.entry_count <= n;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Overwrites one entry; a well-formed rewrite keeps the table in ascending order.
    task automatic rewrite_entry(input bit noise);
        int unsigned         i;
        logic [KEY_IN_W-1:0] lo, hi;
        i = $urandom_range(0, TABLE_DEPTH - 1);
        lo = (i == 0) ? '0 : stim_table[i - 1];
        hi = (i == TABLE_DEPTH - 1) ? '1 : stim_table[i + 1];
        write_entry(i, noise ? KEY_IN_W'($urandom) : KEY_IN_W'($urandom_range(hi, lo)));
    endtask

    function automatic logic [KEY_IN_W-1:0] pick_key(input int unsigned n);
        int unsigned         sel, pos;
        logic [KEY_IN_W-1:0] k;
        sel = $urandom_range(0, 99);
        pos = (n == 0) ? 0 : $urandom_range(0, n - 1);
        if (n == 0 || sel < 20)
            k = $urandom;
        else if (sel < 65)
            k = stim_table[pos];
        else if (sel < 85)
        begin
            k = stim_table[pos];
            k = sel[0] ? k + 1'b1 : k - 1'b1;
        end
        else if (sel < 92)
            k = sel[0] ? '1 : '0;
        else
            k = stim_table[$urandom_range(0, TABLE_DEPTH - 1)];
        return k;
    endfunction

    initial
    begin
        int unsigned         special_counts [10];
        int unsigned         n, sel;
        logic [COUNT_W-1:0]  count;
        logic [KEY_IN_W-1:0] v;
        special_counts = '{TABLE_DEPTH, MAX_COUNT, TABLE_DEPTH + 1, 0, 1, 2, 3,
                           TABLE_DEPTH - 1, TABLE_DEPTH / 2, TABLE_DEPTH / 2 + 1};
        sb = new();
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.cmd = CMD_WRITE;
        item_ch.entry_index = '0;
        item_ch.key = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.entry_count = '0;
        burst_left = 0;
        gapless = 1'b0;
        hold_request = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // An empty table reports not found whatever the key.
        search_key('0);
        search_key('1);
        write_entry(0, 32'h0000_0000);
        write_entry(1, 32'h0000_0005);
        write_entry(2, 32'h0000_0005);
        write_entry(3, 32'h0000_0005);
        write_entry(4, 32'h8000_0000);
        write_entry(5, 32'hFFFF_FFFE);
        write_entry(6, 32'hFFFF_FFFF);
        write_entry(7, 32'hFFFF_FFFF);
        write_entry(TABLE_DEPTH - 1, 32'hFFFF_FFFF);
        set_entry_count(1);
        search_key(32'h0000_0000);
        search_key(32'h0000_0001);
        set_entry_count(8);
        search_key(32'h0000_0005);
        search_key(32'h0000_0000);
        search_key(32'hFFFF_FFFF);
        search_key(32'h0000_0004);
        search_key(32'h0000_0006);
        search_key(32'hFFFF_FFFE);
        search_key(32'h8000_0000);
        search_key(32'h7FFF_FFFF);
        // Break the ordering: the probe sequence stays the same and decides the answer.
        write_entry(3, 32'h0000_0001);
        search_key(32'h0000_0001);
        search_key(32'h0000_0005);

        // Load the whole table in ascending order with runs of duplicates.
        v = $urandom_range(0, 1 << 16);
        for (int unsigned i = 0; i < TABLE_DEPTH; i++)
        begin
            write_entry(i, v);
            if ($urandom_range(0, 3) != 0)
                v = (v > 32'hFFFF_FFFF - (1 << 23)) ? '1 : v + $urandom_range(1, 1 << 23);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            count = (p < 10) ? COUNT_W'(special_counts[p])
                             : COUNT_W'($urandom_range(1, TABLE_DEPTH));
            set_entry_count(count);
            n = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
            gapless = (p % 4 == 2);
            if (p == 1)
                hold_request = 1'b1;
            for (int j = 0; j < PHASE_ITEMS; j++)
            begin
                if (p == 4 && j == PHASE_ITEMS / 2)
                    wait_idle();
                sel = $urandom_range(0, 99);
                if (p >= 20 && sel < 4)
                    rewrite_entry(1'b1);
                else if (sel < 15)
                    rewrite_entry(1'b0);
                else
                    search_key(pick_key(n));
            end
        end

        wait_idle();
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/stbs_pkg.sv
hdl/stbs_if.sv
hdl/stbs_ram.sv
hdl/stbs_front.sv
hdl/stbs_back.sv
hdl/sorted_table_binary_search_unit.sv
dv/tb_sorted_table_binary_search_unit.sv
